/* design/svt_pkg.sv */
`timescale 1ns / 1ps
// svt_pkg: shared types, codes and widths for the sleep vote table.
// No dependencies; imported by the interfaces, svt_ctrl, svt_dp and the core.
package svt_pkg;

  localparam int SLOTS_DEFAULT   = 32;
  localparam int HANDLE_W        = 32;
  localparam int CMD_W           = 2;
  localparam int COUNT_W         = 6;
  localparam int COUNT_FIELD_MAX = 63;
  // Internal count width at the largest table size (256 slots).
  localparam int CNT_EXT_W       = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT    = 2'd0,
    CMD_ACQUIRE = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_QUERY   = 2'd3
  } svt_cmd_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;   // input beat accepted
    logic scan;   // walk the handle store
    logic apply;  // commit the command, capture the result
  } svt_ctrl_t;

  // Datapath -> controller
  typedef struct packed {
    logic need_scan;  // accepted command has to search the table
    logic scan_done;  // handle found or last slot compared
  } svt_stat_t;

endpackage

/* design/svt_cmd_if.sv */
`timescale 1ns / 1ps
// svt_cmd_if: command channel (valid/ready plus command and task handle).
// Depends on svt_pkg.
interface svt_cmd_if import svt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [HANDLE_W-1:0] task_id;

  modport source (output valid, command, task_id, input ready);
  modport sink   (input valid, command, task_id, output ready);
endinterface

/* design/svt_res_if.sv */
`timescale 1ns / 1ps
// svt_res_if: result channel (valid/ready plus success, block flag, count).
// Depends on svt_pkg.
interface svt_res_if import svt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               success;
  logic               sleep_blocked;
  logic [COUNT_W-1:0] active_votes;

  modport source (output valid, success, sleep_blocked, active_votes, input ready);
  modport sink   (input valid, success, sleep_blocked, active_votes, output ready);
endinterface

/* design/svt_ram.sv */
`timescale 1ns / 1ps
// svt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module svt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/svt_ctrl.sv */
`timescale 1ns / 1ps
// svt_ctrl: command sequencer (idle, scan, apply, respond).
// Depends on svt_pkg; drives svt_dp through svt_ctrl_t.
module svt_ctrl import svt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  svt_stat_t stat,
  output svt_ctrl_t ctrl
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_RESP  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready   = (state == ST_IDLE);
  assign out_valid  = (state == ST_RESP);
  assign accept     = in_valid && in_ready;
  assign ctrl.load  = accept;
  assign ctrl.scan  = (state == ST_SCAN);
  assign ctrl.apply = (state == ST_APPLY);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = stat.need_scan ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("svt_ctrl: new beat taken while a command is in flight");

  a_scan_to_apply: assert property (@(posedge clk) disable iff (rst)
    (ctrl.scan && stat.scan_done) |=> ctrl.apply)
    else $error("svt_ctrl: finished scan did not commit");

  a_apply_to_resp: assert property (@(posedge clk) disable iff (rst)
    ctrl.apply |=> out_valid)
    else $error("svt_ctrl: commit not followed by a result beat");

endmodule

/* design/svt_dp.sv */
`timescale 1ns / 1ps
// svt_dp: handle store, vote bits, count and the slot scan pipeline.
// Depends on svt_pkg and svt_ram; sequenced by svt_ctrl.
module svt_dp import svt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  svt_ctrl_t           ctrl,
  output svt_stat_t           stat,
  input  logic [CMD_W-1:0]    in_command,
  input  logic [HANDLE_W-1:0] in_task_id,
  output logic                out_success,
  output logic                out_sleep_blocked,
  output logic [COUNT_W-1:0]  out_active_votes
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  svt_cmd_t            cmd_q;
  logic [HANDLE_W-1:0] handle_q;

  // scan pipeline: issue address, then compare in the next cycle
  logic [IW-1:0]       addr;
  logic                issuing;
  logic                cmp_vld;
  logic [IW-1:0]       cmp_idx;
  logic                cmp_ent;
  logic [HANDLE_W-1:0] rdata;
  logic                hit;

  logic                match_f;
  logic [IW-1:0]       match_idx;
  logic                free_f;
  logic [IW-1:0]       free_idx;

  logic [SLOTS-1:0]    valid_bits;
  logic [SLOTS-1:0]    votes;
  logic [CW-1:0]       count;
  logic                ready_q;

  logic                ok;
  logic                claim;
  logic [CW-1:0]       count_next;
  logic                ready_next;
  logic [CNT_EXT_W-1:0] count_ext;
  logic                read_en;

  assign stat.need_scan = ((svt_cmd_t'(in_command) == CMD_ACQUIRE) ||
                           (svt_cmd_t'(in_command) == CMD_RELEASE)) &&
                          ready_q && (in_task_id != '0);

  assign hit            = cmp_vld && cmp_ent && (rdata == handle_q);
  assign stat.scan_done = hit || (cmp_vld && (cmp_idx == LAST));
  assign read_en        = ctrl.scan && issuing;

  svt_ram #(
    .WIDTH(HANDLE_W),
    .DEPTH(SLOTS)
  ) u_handles (
    .clk  (clk),
    .we   (ctrl.apply && claim),
    .waddr(free_idx),
    .wdata(handle_q),
    .re   (read_en),
    .raddr(addr),
    .rdata(rdata)
  );

  // Command decode at commit
  always_comb begin
    ok         = 1'b0;
    claim      = 1'b0;
    count_next = count;
    ready_next = ready_q;
    unique case (cmd_q)
      CMD_INIT: begin
        count_next = '0;
        ready_next = 1'b1;
      end
      CMD_ACQUIRE: begin
        if (match_f) begin
          ok = !votes[match_idx];
        end else if (free_f) begin
          ok    = 1'b1;
          claim = 1'b1;
        end
        if (ok) begin
          count_next = count + 1'b1;
        end
      end
      CMD_RELEASE: begin
        ok = match_f && votes[match_idx];
        if (ok && (count != '0)) begin
          count_next = count - 1'b1;
        end
      end
      CMD_QUERY: begin
      end
      default: begin
      end
    endcase
  end

  assign count_ext = CNT_EXT_W'(count_next);

  // Command capture and scan
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q    <= svt_cmd_t'(in_command);
      handle_q <= in_task_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      cmp_vld <= 1'b0;
      match_f <= 1'b0;
      free_f  <= 1'b0;
    end else if (ctrl.load) begin
      issuing <= 1'b1;
      cmp_vld <= 1'b0;
      match_f <= 1'b0;
      free_f  <= 1'b0;
    end else if (ctrl.scan) begin
      cmp_vld <= issuing;
      if (issuing) begin
        if (addr == LAST) begin
          issuing <= 1'b0;
        end
        // first unused slot, lowest first
        if (!valid_bits[addr] && !free_f) begin
          free_f <= 1'b1;
        end
      end
      if (hit && !match_f) begin
        match_f <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      addr <= '0;
    end else if (ctrl.scan) begin
      if (issuing) begin
        cmp_idx <= addr;
        cmp_ent <= valid_bits[addr];
        if (addr != LAST) begin
          addr <= addr + 1'b1;
        end
        if (!valid_bits[addr] && !free_f) begin
          free_idx <= addr;
        end
      end
      if (hit && !match_f) begin
        match_idx <= cmp_idx;
      end
    end
  end

  // Table state and result capture
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      votes      <= '0;
      count      <= '0;
      ready_q    <= 1'b0;
    end else if (ctrl.apply) begin
      if (cmd_q == CMD_INIT) begin
        valid_bits <= '0;
        votes      <= '0;
      end else if (ok && (cmd_q == CMD_ACQUIRE)) begin
        if (claim) begin
          votes[free_idx]      <= 1'b1;
          valid_bits[free_idx] <= 1'b1;
        end else begin
          votes[match_idx] <= 1'b1;
        end
      end else if (ok && (cmd_q == CMD_RELEASE)) begin
        votes[match_idx] <= 1'b0;
      end
      count   <= count_next;
      ready_q <= ready_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.apply) begin
      out_success       <= ok;
      out_sleep_blocked <= ready_next && (count_next != '0);
      out_active_votes  <= (count_ext > CNT_EXT_W'(COUNT_FIELD_MAX)) ?
                           COUNT_W'(COUNT_FIELD_MAX) : count_ext[COUNT_W-1:0];
    end
  end

  a_count_matches_votes: assert property (@(posedge clk) disable iff (rst)
    $countones(votes) == int'(count))
    else $error("svt_dp: vote count out of step with vote bits");

  a_idle_table_empty: assert property (@(posedge clk) disable iff (rst)
    !ready_q |-> (count == '0) && (votes == '0))
    else $error("svt_dp: votes present before init");

  a_acquire_counts_up: assert property (@(posedge clk) disable iff (rst)
    (ctrl.apply && ok && (cmd_q == CMD_ACQUIRE)) |=> (count == CW'($past(count) + 1'b1)))
    else $error("svt_dp: successful acquire did not bump the count");

endmodule

/* design/sleep_vote_table_core.sv */
`timescale 1ns / 1ps
// sleep_vote_table_core: top level of the sleep vote table.
// Depends on svt_pkg, svt_cmd_if, svt_res_if, svt_ctrl, svt_dp, svt_ram.
//
// Usage
//   cmd (sink): one beat per command: command (init, acquire, release,
//     query) and a 32-bit task handle. Handle zero is refused.
//   res (source): exactly one beat per command: success (a vote changed),
//     sleep_blocked (table initialized and any vote active) and
//     active_votes (saturated at 63 for tables beyond 63 slots).
//   Until an init command arrives, acquire and release are refused; init
//     wipes every slot and vote, and may be sent at any time.
// Timing
//   Commands are processed one at a time. Init, query, and acquire or release
//   refused for a zero handle or an uninitialized table go from accept to the
//   apply state and then raise result valid in the respond state. Other
//   acquires and releases first scan the handle store one slot per cycle
//   through the RAM read port, stopping at the first match or the last slot.
// Reset and stall
//   rst (synchronous) marks the table uninitialized, clears valid bits,
//   votes and the count; handle RAM contents need no clearing since a slot
//   with a clear valid bit reads as free. While res is stalled the result
//   beat holds and cmd.ready stays low.
module sleep_vote_table_core import svt_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  svt_cmd_if.sink    cmd,
  svt_res_if.source  res
);

  svt_ctrl_t ctrl;
  svt_stat_t stat;

  // Sequencer: owns both handshakes
  svt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (cmd.ready),
    .out_valid(res.valid),
    .out_ready(res.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Datapath: table, scan and the registered result payload
  svt_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_command       (cmd.command),
    .in_task_id       (cmd.task_id),
    .out_success      (res.success),
    .out_sleep_blocked(res.sleep_blocked),
    .out_active_votes (res.active_votes)
  );

endmodule
